// ===== hdl/murmur3_32_hash_assert.svh =====
// ----------------------------------------------------------------------------
// murmur3_32_hash assertion macros
// Concurrent checks on i_clk, held off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MURMUR3_32_HASH_ASSERT_SVH
`define MURMUR3_32_HASH_ASSERT_SVH

`ifndef SYNTHESIS
`define M3H_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("murmur3_32_hash: check failed");
`define M3H_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("murmur3_32_hash: check failed");
`else
`define M3H_ASSERT_SAME(label, ante, cons)
`define M3H_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== hdl/m3h_pkg.sv =====
// ----------------------------------------------------------------------------
// m3h_pkg
// Constants and state codes for the MurmurHash3 x86 32-bit hash block.
// ----------------------------------------------------------------------------
package m3h_pkg;

    localparam logic [31:0] MIX_C1  = 32'hcc9e2d51;
    localparam logic [31:0] MIX_C2  = 32'h1b873593;
    localparam logic [31:0] MIX_ADD = 32'he6546b64;
    localparam logic [31:0] FIN_M1  = 32'h85ebca6b;
    localparam logic [31:0] FIN_M2  = 32'hc2b2ae35;

    localparam logic [2:0]  FULL_COUNT = 3'd4;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_MUL1 = 7'b0000010,
        ST_MUL2 = 7'b0000100,
        ST_MIX  = 7'b0001000,
        ST_FIN1 = 7'b0010000,
        ST_FIN2 = 7'b0100000,
        ST_DONE = 7'b1000000
    } t_state;

    // Keep the valid bytes of a word, 0..4 bytes.
    function automatic logic [31:0] mask_bytes(input logic [31:0] w, input logic [2:0] cnt);
        logic [31:0] m;
        case (cnt)
            3'd0:    m = 32'h00000000;
            3'd1:    m = 32'h000000ff;
            3'd2:    m = 32'h0000ffff;
            3'd3:    m = 32'h00ffffff;
            default: m = 32'hffffffff;
        endcase
        return w & m;
    endfunction

endpackage

// ===== hdl/murmur3_32_hash.sv =====
// ----------------------------------------------------------------------------
// murmur3_32_hash
// MurmurHash3 x86 32-bit, seed 0, over a message of little-endian words.
//
//   channel  dir  handshake            fields
//   input    in   i_valid / o_stall    i_data_word, i_byte_count, i_last_word
//   result   out  o_valid / i_stall    o_hash_value
//
// A word steps through accept, two multiplies and mix; a last word goes on
// through two avalanche multiplies to the output register, as one 32x32
// multiplier is shared by the block scramble and the final avalanche.
// Synchronous active-low reset clears the hash, length and output valid.
// The result waits in an output register; a stalled result holds the block
// in its last step until the register frees.
// ----------------------------------------------------------------------------
module murmur3_32_hash (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_data_word,
    input  logic [2:0]  i_byte_count,
    input  logic        i_last_word,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_hash_value
);

    m3h_pkg::t_state r_state, n_state;

    logic [31:0] r_hash, n_hash;
    logic [31:0] r_len,  n_len;
    logic [31:0] r_k;
    logic [31:0] r_prod;
    logic [2:0]  r_count;
    logic        r_last;
    logic        r_out_valid, n_out_valid;
    logic [31:0] r_out;

    logic        accept;
    logic        out_free;
    logic [2:0]  cnt_clamp;
    logic [31:0] mul_a, mul_b;
    logic [31:0] mul_p;
    logic [31:0] h_x, h_r, h_m, fin_in, len_sum;

    assign accept    = i_valid && !o_stall;
    assign out_free  = !r_out_valid || !i_stall;
    assign cnt_clamp = (i_byte_count > m3h_pkg::FULL_COUNT) ? m3h_pkg::FULL_COUNT
                                                             : i_byte_count;

    assign h_x     = r_hash ^ r_prod;
    assign h_r     = {h_x[18:0], h_x[31:19]};
    assign h_m     = (h_r << 2) + h_r + m3h_pkg::MIX_ADD;
    assign len_sum = r_len + {29'd0, r_count};
    assign fin_in  = r_hash ^ (r_hash >> 16);

    // shared multiplier
    always_comb begin
        mul_a = r_k;
        mul_b = m3h_pkg::MIX_C1;
        unique case (r_state)
            m3h_pkg::ST_MUL2: begin
                mul_a = {r_prod[16:0], r_prod[31:17]};
                mul_b = m3h_pkg::MIX_C2;
            end
            m3h_pkg::ST_FIN1: begin
                mul_a = fin_in;
                mul_b = m3h_pkg::FIN_M1;
            end
            m3h_pkg::ST_FIN2: begin
                mul_a = r_prod ^ (r_prod >> 13);
                mul_b = m3h_pkg::FIN_M2;
            end
            default: begin
                mul_a = r_k;
                mul_b = m3h_pkg::MIX_C1;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_comb begin
        n_state     = r_state;
        n_hash      = r_hash;
        n_len       = r_len;
        n_out_valid = r_out_valid && i_stall;
        unique case (r_state)
            m3h_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = m3h_pkg::ST_MUL1;
                end
            end
            m3h_pkg::ST_MUL1: n_state = m3h_pkg::ST_MUL2;
            m3h_pkg::ST_MUL2: n_state = m3h_pkg::ST_MIX;
            m3h_pkg::ST_MIX: begin
                if (r_last) begin
                    n_hash  = ((r_count == m3h_pkg::FULL_COUNT) ? h_m : h_x) ^ len_sum;
                    n_len   = '0;
                    n_state = m3h_pkg::ST_FIN1;
                end else begin
                    n_hash  = h_m;
                    n_len   = len_sum;
                    n_state = m3h_pkg::ST_IDLE;
                end
            end
            m3h_pkg::ST_FIN1: n_state = m3h_pkg::ST_FIN2;
            m3h_pkg::ST_FIN2: n_state = m3h_pkg::ST_DONE;
            m3h_pkg::ST_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_hash      = '0;
                    n_state     = m3h_pkg::ST_IDLE;
                end
            end
            default: n_state = m3h_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= m3h_pkg::ST_IDLE;
            r_hash      <= '0;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_hash      <= n_hash;
            r_len       <= n_len;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_k     <= m3h_pkg::mask_bytes(i_data_word, cnt_clamp);
            r_count <= cnt_clamp;
            r_last  <= i_last_word || (cnt_clamp != m3h_pkg::FULL_COUNT);
        end
        // product held while the result waits
        if (r_state != m3h_pkg::ST_DONE) begin
            r_prod <= mul_p;
        end
        if (r_state == m3h_pkg::ST_DONE && out_free) begin
            r_out <= r_prod ^ (r_prod >> 16);
        end
    end

    assign o_stall      = (r_state != m3h_pkg::ST_IDLE);
    assign o_valid      = r_out_valid;
    assign o_hash_value = r_out;

`include "murmur3_32_hash_assert.svh"

    `M3H_ASSERT_NEXT(a_accept_starts, accept, r_state == m3h_pkg::ST_MUL1)
    `M3H_ASSERT_NEXT(a_done_clears, r_state == m3h_pkg::ST_DONE && out_free, o_valid && r_hash == 32'd0 && r_len == 32'd0)
    `M3H_ASSERT_SAME(a_fin_len_zero, r_state == m3h_pkg::ST_FIN1 || r_state == m3h_pkg::ST_FIN2, r_len == 32'd0)
    `M3H_ASSERT_SAME(a_count_range, r_state == m3h_pkg::ST_MIX, r_count <= m3h_pkg::FULL_COUNT)

endmodule

// ===== dv/murmur3_32_hash_tb.sv =====
// ----------------------------------------------------------------------------
// murmur3_32_hash_tb
// Streams byte messages into the hash block as little-endian words and checks
// every finished hash against a local MurmurHash3 x86 32-bit predictor.
// Directed words cover empty and short messages, full words, aliased counts
// and dead bytes above the count. Random messages follow, mostly well formed,
// with random idling on the input and random stall on the output.
// ----------------------------------------------------------------------------
module murmur3_32_hash_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [31:0] H_MUL      = 32'd5;
    localparam int          IDLE_PCT   = 21;
    localparam int          NUM_WORDS  = 1800;
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          MAX_REPORTS = 10;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_valid      = 1'b0;
    logic [31:0] i_data_word  = '0;
    logic [2:0]  i_byte_count = '0;
    logic        i_last_word  = 1'b0;
    logic        i_stall      = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [31:0] o_hash_value;

    logic [31:0] acc_hash = '0;
    logic [31:0] acc_len  = '0;
    logic [31:0] hash_expect_q[$];

    int  words_sent = 0;
    int  err_cnt    = 0;
    int  cycle_cnt  = 0;
    bit  tx_quiet   = 1'b0;
    bit  rx_quiet   = 1'b0;

    murmur3_32_hash u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_data_word  (i_data_word),
        .i_byte_count (i_byte_count),
        .i_last_word  (i_last_word),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_hash_value (o_hash_value)
    );

    always #6ns i_clk = ~i_clk;

    function automatic logic [31:0] rotl32(input logic [31:0] v, input int unsigned n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic logic [31:0] scramble32(input logic [31:0] k);
        logic [31:0] t;
        t = k * m3h_pkg::MIX_C1;
        t = rotl32(t, 15);
        return t * m3h_pkg::MIX_C2;
    endfunction

    function automatic logic [31:0] fmix32(input logic [31:0] h);
        logic [31:0] t;
        t = h ^ (h >> 16);
        t = t * m3h_pkg::FIN_M1;
        t = t ^ (t >> 13);
        t = t * m3h_pkg::FIN_M2;
        return t ^ (t >> 16);
    endfunction

    // Advance the running hash by one word; queue the hash when the message ends.
    task automatic predict_word(input logic [31:0] w, input logic [2:0] c, input logic l);
        logic [2:0]  n;
        logic [31:0] h;
        logic [31:0] k;
        logic        ends;
        n    = (c > m3h_pkg::FULL_COUNT) ? m3h_pkg::FULL_COUNT : c;
        h    = acc_hash;
        ends = l;
        if (n == m3h_pkg::FULL_COUNT) begin
            h = h ^ scramble32(w);
            h = rotl32(h, 13);
            h = h * H_MUL + m3h_pkg::MIX_ADD;
        end else begin
            k = w & ((32'h1 << (8 * n)) - 32'h1);
            if (n != 3'd0) begin
                h = h ^ scramble32(k);
            end
            ends = 1'b1;
        end
        acc_len = acc_len + {29'd0, n};
        if (ends) begin
            hash_expect_q = {hash_expect_q, fmix32(h ^ acc_len)};
            acc_hash = '0;
            acc_len  = '0;
        end else begin
            acc_hash = h;
        end
    endtask

    task automatic send_word(input logic [31:0] w, input logic [2:0] c, input logic l);
        while (!tx_quiet && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        predict_word(w, c, l);
        i_valid      <= 1'b1;
        i_data_word  <= w;
        i_byte_count <= c;
        i_last_word  <= l;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        words_sent++;
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (hash_expect_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Result side: random stall, compare each accepted hash in order.
    always @(posedge i_clk) begin
        logic [31:0] want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (hash_expect_q.size() == 0) begin
                err_cnt++;
                if (err_cnt <= MAX_REPORTS) begin
                    $display("unexpected hash %08h at cycle %0d", o_hash_value, cycle_cnt);
                end
            end else begin
                want = hash_expect_q.pop_front();
                if (o_hash_value !== want) begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS) begin
                        $display("hash mismatch: expected %08h, got %08h at cycle %0d",
                                 want, o_hash_value, cycle_cnt);
                    end
                end
            end
        end
        i_stall <= !rx_quiet && ($urandom_range(0, 99) < IDLE_PCT);
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("murmur3_32_hash_tb: FAIL");
            $finish;
        end
    end

    task automatic test_short_messages();
        send_word(32'h0000_0000, 3'd0, 1'b1);
        send_word(32'hffff_ffff, 3'd0, 1'b0);
        send_word(32'hffff_ff5a, 3'd1, 1'b1);
        send_word(32'hdead_beef, 3'd2, 1'b1);
        send_word(32'h8012_3456, 3'd3, 1'b0);
        send_word(32'hffff_ffff, 3'd3, 1'b1);
    endtask

    task automatic test_full_words();
        send_word(32'h0000_0000, 3'd4, 1'b1);
        send_word(32'hffff_ffff, 3'd4, 1'b0);
        send_word(32'hffff_ffff, 3'd4, 1'b1);
        send_word(32'h6c6c_6548, 3'd4, 1'b0);
        send_word(32'hffff_ffff, 3'd0, 1'b0);
        send_word(32'h0403_0201, 3'd4, 1'b0);
        send_word(32'h5a07_0605, 3'd3, 1'b1);
    endtask

    task automatic test_count_aliases();
        send_word(32'h1234_5678, 3'd5, 1'b0);
        send_word(32'h9abc_def0, 3'd6, 1'b0);
        send_word(32'hffff_0000, 3'd7, 1'b1);
        send_word(32'h0f0f_0f0f, 3'd7, 1'b0);
        send_word(32'hf0f0_f0f0, 3'd1, 1'b0);
    endtask

    task automatic test_back_pressure();
        repeat (3) send_word($urandom, 3'd4, 1'b0);
        send_word($urandom, 3'd2, 1'b1);
        wait_drained();
        send_word($urandom, 3'd4, 1'b1);
        wait_drained();
    endtask

    task automatic test_random_messages();
        int nfull;
        while (words_sent < NUM_WORDS) begin
            tx_quiet = (words_sent >= 700 && words_sent < 1000);
            rx_quiet = tx_quiet;
            if ($urandom_range(0, 9) == 0) begin
                send_word($urandom, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
            end else begin
                nfull = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40)
                                                    : $urandom_range(0, 6);
                repeat (nfull) begin
                    send_word($urandom,
                              ($urandom_range(0, 7) == 0) ? 3'($urandom_range(5, 7)) : 3'd4,
                              1'b0);
                end
                if ($urandom_range(0, 3) == 0) begin
                    send_word($urandom, 3'($urandom_range(4, 7)), 1'b1);
                end else begin
                    send_word($urandom, 3'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
                end
            end
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_short_messages();
        test_full_words();
        test_count_aliases();
        test_back_pressure();
        test_random_messages();
        wait_drained();
        repeat (20) @(posedge i_clk);
        if (err_cnt == 0 && hash_expect_q.size() == 0) begin
            $display("murmur3_32_hash_tb: PASS");
        end else begin
            $display("murmur3_32_hash_tb: FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/m3h_pkg.sv
hdl/murmur3_32_hash.sv
dv/murmur3_32_hash_tb.sv
